/* sv/sbcp_pkg.sv */
// Package for the sub-byte code packer: register indexes, code masks,
// result and state types shared by the packer modules.
// No dependencies.
package sbcp_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCodeWidthMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCodesPerVector = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTotalVectors  = 2'd2;

  // Code width modes.
  localparam logic [1:0] ModeFour   = 2'd0;
  localparam logic [1:0] ModeFive   = 2'd1;
  localparam logic [1:0] ModeSix    = 2'd2;
  localparam logic [1:0] ModeByte   = 2'd3;

  localparam logic [7:0] MaskFour = 8'h0f;
  localparam logic [7:0] MaskFive = 8'h1f;
  localparam logic [7:0] MaskSix  = 8'h3f;
  localparam logic [7:0] MaskByte = 8'hff;

  // A vector never holds more codes than this.
  localparam logic [16:0] MaxCodes = 17'd65535;

  // Depth of the result queue; one item pushes at most two results.
  localparam int QueueDepth = 3;
  localparam int QueueCntW  = 2;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       vector_end;
    logic       data_end;
    logic       run_end;
  } result_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [2:0]  held;
    logic [15:0] code_idx;
    logic [23:0] vec_idx;
  } state_t;

endpackage

/* sv/sbcp_pack_step.sv */
// Combinational packing step: appends one code to the bit accumulator and
// forms up to two output bytes and the next packer state.
// Depends on sbcp_pkg.
module sbcp_pack_step (
  input  logic [7:0]                  code_i,
  input  logic [1:0]                  mode_i,
  input  logic [15:0]                 codes_per_vector_i,
  input  logic [23:0]                 total_vectors_i,
  input  sbcp_pkg::state_t            state_i,
  output logic [1:0]                  num_o,
  output sbcp_pkg::result_t           res0_o,
  output sbcp_pkg::result_t           res1_o,
  output sbcp_pkg::state_t            state_o
);

  logic [7:0]  mask;
  logic [3:0]  width;
  logic [6:0]  held_mask;
  logic [14:0] acc_ext;
  logic [3:0]  total;
  logic        full;
  logic [2:0]  rem_total;
  logic [16:0] next_code;
  logic [24:0] next_vec;
  logic        last_code;
  logic        last_vec;
  logic        two;

  always_comb begin
    case (mode_i)
      sbcp_pkg::ModeFour: begin
        mask  = sbcp_pkg::MaskFour;
        width = 4'd4;
      end
      sbcp_pkg::ModeFive: begin
        mask  = sbcp_pkg::MaskFive;
        width = 4'd5;
      end
      sbcp_pkg::ModeSix: begin
        mask  = sbcp_pkg::MaskSix;
        width = 4'd6;
      end
      default: begin
        mask  = sbcp_pkg::MaskByte;
        width = 4'd8;
      end
    endcase
  end

  assign held_mask = 7'((8'h01 << state_i.held) - 8'h01);
  assign acc_ext   = 15'(state_i.acc[6:0] & held_mask)
                   | (15'(code_i & mask) << state_i.held);
  assign total     = 4'(state_i.held) + width;
  assign full      = total[3];
  // Whether or not a full byte leaves, the bits left over are the low three.
  assign rem_total = total[2:0];

  assign next_code = 17'(state_i.code_idx) + 17'd1;
  assign next_vec  = 25'(state_i.vec_idx) + 25'd1;
  assign last_code = (next_code >= 17'(codes_per_vector_i))
                  || (next_code >= sbcp_pkg::MaxCodes);
  assign last_vec  = next_vec >= 25'(total_vectors_i);
  assign two       = last_code && full && (rem_total != 3'd0);

  always_comb begin
    res0_o.packed_byte = acc_ext[7:0];
    res0_o.vector_end  = last_code && !two;
    res0_o.data_end    = last_code && last_vec && !two;
    res0_o.run_end     = !two;

    res1_o.packed_byte = {1'b0, acc_ext[14:8]};
    res1_o.vector_end  = 1'b1;
    res1_o.data_end    = last_vec;
    res1_o.run_end     = 1'b1;

    if (last_code) begin
      num_o            = two ? 2'd2 : 2'd1;
      state_o.acc      = 8'h00;
      state_o.held     = 3'd0;
      state_o.code_idx = 16'd0;
      state_o.vec_idx  = last_vec ? 24'd0 : next_vec[23:0];
    end else begin
      num_o            = {1'b0, full};
      state_o.acc      = full ? {1'b0, acc_ext[14:8]} : acc_ext[7:0];
      state_o.held     = rem_total;
      state_o.code_idx = next_code[15:0];
      state_o.vec_idx  = state_i.vec_idx;
    end
  end

endmodule

/* sv/sbcp_out_queue.sv */
// Result queue of three entries: takes up to two results per cycle and
// presents the oldest one on a valid/ready channel.
// Depends on sbcp_pkg.
module sbcp_out_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  push_num_i,
  input  sbcp_pkg::result_t           push0_i,
  input  sbcp_pkg::result_t           push1_i,
  output logic [sbcp_pkg::QueueCntW-1:0] room_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sbcp_pkg::result_t           out_o
);

  sbcp_pkg::result_t slot_q [sbcp_pkg::QueueDepth];
  sbcp_pkg::result_t slot_d [sbcp_pkg::QueueDepth];
  sbcp_pkg::result_t shifted [sbcp_pkg::QueueDepth];
  logic [sbcp_pkg::QueueCntW-1:0] count_q, count_d;
  logic [sbcp_pkg::QueueCntW-1:0] base;
  logic pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_o       = slot_q[0];
  assign room_o      = sbcp_pkg::QueueCntW'(sbcp_pkg::QueueDepth) - count_q;
  assign base        = count_q - sbcp_pkg::QueueCntW'(pop);

  always_comb begin
    for (int i = 0; i < sbcp_pkg::QueueDepth; i++) begin
      if (pop && (i < sbcp_pkg::QueueDepth - 1)) begin
        shifted[i] = slot_q[i+1];
      end else begin
        shifted[i] = slot_q[i];
      end
    end
    for (int i = 0; i < sbcp_pkg::QueueDepth; i++) begin
      if ((push_num_i != 2'd0) && (sbcp_pkg::QueueCntW'(i) == base)) begin
        slot_d[i] = push0_i;
      end else if ((push_num_i == 2'd2)
                   && (sbcp_pkg::QueueCntW'(i) == base + 2'd1)) begin
        slot_d[i] = push1_i;
      end else begin
        slot_d[i] = shifted[i];
      end
    end
    count_d = base + push_num_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

/* sv/sub_byte_code_packer_core.sv */
// Sub-byte code packer, top level. Packs 4, 5 or 6-bit codes (or raw bytes)
// LSB first into bytes, flushing a partial byte at the end of each vector.
// Depends on sbcp_pkg, sbcp_pack_step and sbcp_out_queue.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, code_i) carries one code per
//   transaction. Output channel (out_valid_o/out_ready_i) carries one packed
//   byte per transaction with vector_end_o, data_end_o and run_end_o flags.
//   Each code causes zero, one or two bytes. The configuration channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes code width
//   mode, codes per vector and total vectors; it is always ready. The user
//   must see that it is written only while the packer is idle; the block
//   itself does not enforce this. A code is first captured in the input
//   register; once the result queue has room for all of its bytes, they
//   are written into the queue, which offers the oldest. Throughput: one
//   code per cycle while each code yields at most one byte and the queue
//   has room; the output moves one byte per cycle via the three-entry queue.
//   Reset clears the pipeline, the queue, the packing state and restores
//   register defaults (four-bit mode, one code per vector, one vector).
//   When the receiver stalls, results collect in the queue; once it cannot
//   take the next code's bytes, the input register holds and in_ready_o
//   drops.
module sub_byte_code_packer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sbcp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    packed_byte_o,
  output logic                          vector_end_o,
  output logic                          data_end_o,
  output logic                          run_end_o
);

  logic [1:0]  mode_q;
  logic [15:0] cpv_q;
  logic [23:0] tv_q;

  logic        in_v_q;
  logic [7:0]  code_q;

  sbcp_pkg::state_t  state_q, state_d;
  sbcp_pkg::result_t res0, res1, out_res;
  logic [1:0] step_num;
  logic [1:0] push_num;
  logic [sbcp_pkg::QueueCntW-1:0] room;
  logic fire;
  logic in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sbcp_pkg::ModeFour;
      cpv_q  <= 16'd1;
      tv_q   <= 24'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbcp_pkg::RegCodeWidthMode:  mode_q <= cfg_data_i[1:0];
        sbcp_pkg::RegCodesPerVector: cpv_q  <= cfg_data_i[15:0];
        sbcp_pkg::RegTotalVectors:   tv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbcp_pack_step u_step (
    .code_i             (code_q),
    .mode_i             (mode_q),
    .codes_per_vector_i (cpv_q),
    .total_vectors_i    (tv_q),
    .state_i            (state_q),
    .num_o              (step_num),
    .res0_o             (res0),
    .res1_o             (res1),
    .state_o            (state_d)
  );

  // The code leaves the input register only when the queue can hold all
  // of its bytes, so the decision never waits on out_ready_i.
  assign fire       = in_v_q && (step_num <= room);
  assign push_num   = fire ? step_num : 2'd0;
  assign in_ready_o = !in_v_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      state_q <= '0;
    end else begin
      if (in_acc) begin
        in_v_q <= 1'b1;
      end else if (fire) begin
        in_v_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= code_i;
    end
  end

  sbcp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign packed_byte_o = out_res.packed_byte;
  assign vector_end_o  = out_res.vector_end;
  assign data_end_o    = out_res.data_end;
  assign run_end_o     = out_res.run_end;

  // Pending bits only exist in the middle of a vector.
  a_held_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.held != 3'd0) |-> (state_q.code_idx != 16'd0))
    else $error("pending bits at a vector boundary");

  // Accumulator bits above the pending count stay clear.
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.acc >> state_q.held) == 8'h00)
    else $error("stray accumulator bits");

  // A code held back in the input register keeps its value.
  a_hold_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !fire) |=> (in_v_q && $stable(code_q)))
    else $error("held code lost");

  // The end of the data set is always the end of a vector and of a run.
  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (data_end_o || vector_end_o)) |-> (vector_end_o && run_end_o))
    else $error("inconsistent end flags");

  // The packing state changes only when a code leaves the input register.
  a_state_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("state changed without a code");

endmodule
